// ===== hw/rtl/socd_pkg.sv =====
// Shared constants for the SOCD cleaner and stick scaling block.
package socd_pkg;

  // Default sample width of the converter channels
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // Field widths
  localparam int unsigned DIR_W    = 4;
  localparam int unsigned BTN_W    = 8;
  localparam int unsigned REPORT_W = 8;

  // Direction key bit positions
  localparam int unsigned DIR_LEFT  = 0;
  localparam int unsigned DIR_RIGHT = 1;
  localparam int unsigned DIR_UP    = 2;
  localparam int unsigned DIR_DOWN  = 3;

  // Button key bit positions used for the triggers
  localparam int unsigned BTN_L = 5;
  localparam int unsigned BTN_R = 6;

  // Stick clamp window and output scale
  localparam int unsigned CLAMP_LO   = 965;
  localparam int unsigned CLAMP_HI   = 3180;
  localparam int unsigned SCALE_MUL  = 192;
  localparam int unsigned SCALE_DIV  = 2215;
  localparam int unsigned REPORT_LO  = 32;
  localparam int unsigned REPORT_HI  = 224;
  localparam int unsigned TRIGGER_ON = 224;

  // Offset from the clamp floor fits in this many bits (0..2215)
  localparam int unsigned DIFF_W = 12;

  // Divide by SCALE_DIV as a multiply by a rounded-up reciprocal; the shift is
  // large enough that the product error stays below one step of the divisor
  localparam int unsigned SCALE_SHIFT = 23;
  localparam longint unsigned SCALE_RECIP =
    ((longint'(SCALE_MUL) << SCALE_SHIFT) + longint'(SCALE_DIV) - 1) / longint'(SCALE_DIV);
  localparam int unsigned RECIP_W = 20;
  localparam int unsigned PROD_W  = 32;

endpackage

// ===== hw/rtl/socd_scale.sv =====
// Clamp one stick sample to the usable window and scale it to the report range.
module socd_scale #(
  parameter int unsigned SAMPLE_BITS = socd_pkg::SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0]        sample,
  output logic [socd_pkg::REPORT_W-1:0] report
);
  import socd_pkg::*;

  localparam int unsigned CW = (SAMPLE_BITS > DIFF_W) ? SAMPLE_BITS : DIFF_W;
  localparam logic [CW-1:0] ClampLo = CW'(CLAMP_LO);
  localparam logic [CW-1:0] ClampHi = CW'(CLAMP_HI);

  logic [CW-1:0]      wide;
  logic [CW-1:0]      clamped;
  logic [DIFF_W-1:0]  diff;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;

  // Clamp to the window
  always_comb begin
    wide = CW'(sample);
    if (wide > ClampHi) begin
      clamped = ClampHi;
    end else if (wide < ClampLo) begin
      clamped = ClampLo;
    end else begin
      clamped = wide;
    end
  end

  // Offset, multiply by the reciprocal, take the integer part and add the floor
  assign diff   = clamped[DIFF_W-1:0] - DIFF_W'(CLAMP_LO);
  assign recip  = RECIP_W'(SCALE_RECIP);
  assign prod   = PROD_W'(diff) * PROD_W'(recip);
  assign report = prod[SCALE_SHIFT +: REPORT_W] + REPORT_W'(REPORT_LO);

endmodule

// ===== hw/rtl/socd_cleaner_with_stick_scaling_unit.sv =====
// Top level: controller report builder with SOCD cleaning and stick scaling.
//
// Usage:
//   One input word is one poll: four stick samples, four direction keys and
//   eight button keys. Each poll gives exactly one report word.
//   Both channels use valid/stall; a word moves at a rising edge with valid
//   high and stall low.
// Flow:
//   An input register feeds the scaling and cleaning logic, which loads the
//   output register; a taken poll passes through both registers in turn.
//   One poll is taken every cycle unless the receiver stalls; the rate is set by
//   the single pass through the four clamp-and-multiply lanes between the registers.
// Stall:
//   While the receiver stalls, the report holds; the input register still
//   takes a poll if it is empty, after which in_stall rises until the report is taken.
// Reset:
//   rst empties both registers and clears the key history and direction locks.
module socd_cleaner_with_stick_scaling_unit #(
  parameter int unsigned SAMPLE_BITS = socd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [SAMPLE_BITS-1:0]        adc_sample_ch0,
  input  logic [SAMPLE_BITS-1:0]        adc_sample_ch1,
  input  logic [SAMPLE_BITS-1:0]        adc_sample_ch2,
  input  logic [SAMPLE_BITS-1:0]        adc_sample_ch3,
  input  logic [socd_pkg::DIR_W-1:0]    direction_keys,
  input  logic [socd_pkg::BTN_W-1:0]    button_keys,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [socd_pkg::REPORT_W-1:0] main_x_report,
  output logic [socd_pkg::REPORT_W-1:0] main_y_report,
  output logic [socd_pkg::REPORT_W-1:0] cstick_x_report,
  output logic [socd_pkg::REPORT_W-1:0] cstick_y_report,
  output logic                          pad_left,
  output logic                          pad_right,
  output logic                          pad_up,
  output logic                          pad_down,
  output logic [socd_pkg::REPORT_W-1:0] trigger_left_level,
  output logic [socd_pkg::REPORT_W-1:0] trigger_right_level,
  output logic [socd_pkg::BTN_W-1:0]    button_report
);
  import socd_pkg::*;

  // Input register
  logic                   in_reg_valid;
  logic [SAMPLE_BITS-1:0] in_ch0;
  logic [SAMPLE_BITS-1:0] in_ch1;
  logic [SAMPLE_BITS-1:0] in_ch2;
  logic [SAMPLE_BITS-1:0] in_ch3;
  logic [DIR_W-1:0]       in_dir;
  logic [BTN_W-1:0]       in_btn;

  // Key history
  logic [DIR_W-1:0] held_last_poll;
  logic [DIR_W-1:0] locked_until_release;
  logic [DIR_W-1:0] new_lock;
  logic [DIR_W-1:0] locked_until_release_next;
  logic [DIR_W-1:0] clean;

  // Scaled lanes
  logic [REPORT_W-1:0] scaled_ch0;
  logic [REPORT_W-1:0] scaled_ch1;
  logic [REPORT_W-1:0] scaled_ch2;
  logic [REPORT_W-1:0] scaled_ch3;

  logic out_adv;
  logic in_adv;
  logic in_take;
  logic move;

  // Handshake: each register advances when its successor has room
  assign out_adv  = !out_valid || !out_stall;
  assign in_adv   = !in_reg_valid || out_adv;
  assign in_stall = !in_adv;
  assign in_take  = in_valid && in_adv;
  assign move     = in_reg_valid && out_adv;

  // Lock the direction held alone last poll when its opposite is newly pressed
  always_comb begin
    new_lock            = '0;
    new_lock[DIR_LEFT]  = held_last_poll[DIR_LEFT] && in_dir[DIR_LEFT] &&
                          in_dir[DIR_RIGHT] && !held_last_poll[DIR_RIGHT];
    new_lock[DIR_RIGHT] = held_last_poll[DIR_RIGHT] && in_dir[DIR_RIGHT] &&
                          in_dir[DIR_LEFT] && !held_last_poll[DIR_LEFT];
    new_lock[DIR_UP]    = held_last_poll[DIR_UP] && in_dir[DIR_UP] &&
                          in_dir[DIR_DOWN] && !held_last_poll[DIR_DOWN];
    new_lock[DIR_DOWN]  = held_last_poll[DIR_DOWN] && in_dir[DIR_DOWN] &&
                          in_dir[DIR_UP] && !held_last_poll[DIR_UP];
    // Drop locks whose key is released
    locked_until_release_next = (locked_until_release | new_lock) & in_dir;
    clean = in_dir & ~locked_until_release_next;
  end

  // Scaling lanes
  socd_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_ch0 (.sample(in_ch0), .report(scaled_ch0));
  socd_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_ch1 (.sample(in_ch1), .report(scaled_ch1));
  socd_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_ch2 (.sample(in_ch2), .report(scaled_ch2));
  socd_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_ch3 (.sample(in_ch3), .report(scaled_ch3));

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid         <= 1'b0;
      out_valid            <= 1'b0;
      held_last_poll       <= '0;
      locked_until_release <= '0;
    end else begin
      if (in_adv) begin
        in_reg_valid <= in_valid;
      end
      if (out_adv) begin
        out_valid <= in_reg_valid;
      end
      if (move) begin
        held_last_poll       <= in_dir;
        locked_until_release <= locked_until_release_next;
      end
    end
  end

  // Load the input word
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_ch0 <= adc_sample_ch0;
      in_ch1 <= adc_sample_ch1;
      in_ch2 <= adc_sample_ch2;
      in_ch3 <= adc_sample_ch3;
      in_dir <= direction_keys;
      in_btn <= button_keys;
    end
  end

  // Load the report word
  always_ff @(posedge clk) begin
    if (move) begin
      main_x_report       <= scaled_ch2;
      main_y_report       <= scaled_ch3;
      cstick_x_report     <= scaled_ch0;
      cstick_y_report     <= scaled_ch1;
      pad_left            <= clean[DIR_LEFT];
      pad_right           <= clean[DIR_RIGHT];
      pad_up              <= clean[DIR_UP];
      pad_down            <= clean[DIR_DOWN];
      trigger_left_level  <= in_btn[BTN_L] ? REPORT_W'(TRIGGER_ON) : '0;
      trigger_right_level <= in_btn[BTN_R] ? REPORT_W'(TRIGGER_ON) : '0;
      button_report       <= in_btn;
    end
  end

endmodule

// ===== hw/rtl/socd_checker.sv =====
// Port-level checks for the SOCD cleaner top level, with its bind.
module socd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [socd_pkg::REPORT_W-1:0] main_x_report,
  input logic [socd_pkg::REPORT_W-1:0] cstick_y_report,
  input logic [socd_pkg::REPORT_W-1:0] trigger_left_level,
  input logic [socd_pkg::BTN_W-1:0]    button_report
);
  import socd_pkg::*;

  // Hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("report word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(main_x_report) && $stable(button_report))
    else $error("report word changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("report valid right after reset");

  // Two scaled sticks, main x and c-stick y, stay in the report range
  a_stick_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> main_x_report >= REPORT_W'(REPORT_LO) &&
                  main_x_report <= REPORT_W'(REPORT_HI) &&
                  cstick_y_report >= REPORT_W'(REPORT_LO) &&
                  cstick_y_report <= REPORT_W'(REPORT_HI))
    else $error("stick report out of range");

  // Left trigger level follows the L button
  a_trigger_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (button_report[BTN_L] && trigger_left_level == REPORT_W'(TRIGGER_ON)) ||
                  (!button_report[BTN_L] && trigger_left_level == '0))
    else $error("left trigger level disagrees with l button");

endmodule

bind socd_cleaner_with_stick_scaling_unit socd_checker u_socd_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .main_x_report      (main_x_report),
  .cstick_y_report    (cstick_y_report),
  .trigger_left_level (trigger_left_level),
  .button_report      (button_report)
);

// ===== tb/tb.sv =====
// Testbench for the SOCD cleaner and stick scaling unit: directed, random and back-pressure polls.
`timescale 1ns / 1ps

module tb;
  import socd_pkg::*;

  localparam int unsigned SB             = SAMPLE_BITS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned HOLD_OFF_LEN   = 150;

  typedef struct packed {
    logic [SB-1:0]    ch0;
    logic [SB-1:0]    ch1;
    logic [SB-1:0]    ch2;
    logic [SB-1:0]    ch3;
    logic [DIR_W-1:0] dir;
    logic [BTN_W-1:0] btn;
  } poll_t;

  typedef struct packed {
    logic [REPORT_W-1:0] main_x;
    logic [REPORT_W-1:0] main_y;
    logic [REPORT_W-1:0] cs_x;
    logic [REPORT_W-1:0] cs_y;
    logic [DIR_W-1:0]    pad;
    logic [REPORT_W-1:0] trig_l;
    logic [REPORT_W-1:0] trig_r;
    logic [BTN_W-1:0]    btn;
  } report_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [SB-1:0]       adc_sample_ch0;
  logic [SB-1:0]       adc_sample_ch1;
  logic [SB-1:0]       adc_sample_ch2;
  logic [SB-1:0]       adc_sample_ch3;
  logic [DIR_W-1:0]    direction_keys;
  logic [BTN_W-1:0]    button_keys;
  logic                out_valid;
  logic                out_stall;
  logic [REPORT_W-1:0] main_x_report;
  logic [REPORT_W-1:0] main_y_report;
  logic [REPORT_W-1:0] cstick_x_report;
  logic [REPORT_W-1:0] cstick_y_report;
  logic                pad_left;
  logic                pad_right;
  logic                pad_up;
  logic                pad_down;
  logic [REPORT_W-1:0] trigger_left_level;
  logic [REPORT_W-1:0] trigger_right_level;
  logic [BTN_W-1:0]    button_report;

  // Predictor state: keys of the previous poll and locked-out directions
  logic [DIR_W-1:0] key_history;
  logic [DIR_W-1:0] dir_lock;
  report_t          pending_reports[$];

  int unsigned err_cnt;
  int unsigned polls_sent;
  int unsigned reports_seen;
  int unsigned locks_set;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned hold_len;
  int unsigned hold_id;
  int unsigned hold_taken;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  socd_cleaner_with_stick_scaling_unit uut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .adc_sample_ch0      (adc_sample_ch0),
    .adc_sample_ch1      (adc_sample_ch1),
    .adc_sample_ch2      (adc_sample_ch2),
    .adc_sample_ch3      (adc_sample_ch3),
    .direction_keys      (direction_keys),
    .button_keys         (button_keys),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .main_x_report       (main_x_report),
    .main_y_report       (main_y_report),
    .cstick_x_report     (cstick_x_report),
    .cstick_y_report     (cstick_y_report),
    .pad_left            (pad_left),
    .pad_right           (pad_right),
    .pad_up              (pad_up),
    .pad_down            (pad_down),
    .trigger_left_level  (trigger_left_level),
    .trigger_right_level (trigger_right_level),
    .button_report       (button_report)
  );

  // Free-running clock, 2 ns period
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Clamp a sample to the stick window and scale it to the report range
  function automatic logic [REPORT_W-1:0] scale_stick(input logic [SB-1:0] raw);
    int unsigned s;
    s = raw;
    if (s > CLAMP_HI) s = CLAMP_HI;
    if (s < CLAMP_LO) s = CLAMP_LO;
    return REPORT_W'(((s - CLAMP_LO) * SCALE_MUL) / SCALE_DIV + REPORT_LO);
  endfunction

  // Advance the key history and locks for one poll and queue the report it yields
  task automatic predict_report(input poll_t p);
    report_t    r;
    logic [DIR_W-1:0] cur;
    int unsigned opp;
    cur = p.dir;
    for (int unsigned me = 0; me < DIR_W; me++) begin
      // opposing keys share an axis: left/right and up/down differ in bit 0
      opp = me ^ 1;
      if (key_history[me] && cur[me] && cur[opp] && !key_history[opp]) begin
        if (!dir_lock[me]) locks_set++;
        dir_lock[me] = 1'b1;
      end
    end
    dir_lock    = dir_lock & cur;
    key_history = cur;
    r.main_x = scale_stick(p.ch2);
    r.main_y = scale_stick(p.ch3);
    r.cs_x   = scale_stick(p.ch0);
    r.cs_y   = scale_stick(p.ch1);
    r.pad    = cur & ~dir_lock;
    r.trig_l = p.btn[BTN_L] ? REPORT_W'(TRIGGER_ON) : '0;
    r.trig_r = p.btn[BTN_R] ? REPORT_W'(TRIGGER_ON) : '0;
    r.btn    = p.btn;
    pending_reports.push_back(r);
  endtask

  // Offer one poll word, with a random gap first; called and returns at a falling edge
  task automatic send_poll(input poll_t p);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    adc_sample_ch0 <= p.ch0;
    adc_sample_ch1 <= p.ch1;
    adc_sample_ch2 <= p.ch2;
    adc_sample_ch3 <= p.ch3;
    direction_keys <= p.dir;
    button_keys    <= p.btn;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_report(p);
    polls_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every queued report has been taken
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  function automatic logic [SB-1:0] pick_sample();
    case ($urandom_range(0, 3))
      0:       return SB'($urandom);
      1:       return SB'($urandom_range(CLAMP_LO - 12, CLAMP_LO + 12));
      2:       return SB'($urandom_range(CLAMP_HI - 12, CLAMP_HI + 12));
      default: return SB'($urandom_range(CLAMP_LO, CLAMP_HI));
    endcase
  endfunction

  // Clamp edges, crosswise channel mapping, trigger and button extremes
  task automatic test_sample_extremes();
    send_poll('{12'd0,    12'd4095, 12'd964,  12'd3181, 4'h0, 8'h00});
    send_poll('{12'd965,  12'd3180, 12'd966,  12'd3179, 4'hF, 8'hFF});
    send_poll('{12'd4095, 12'd0,    12'd3180, 12'd965,  4'h0, 8'h20});
    send_poll('{12'd1076, 12'd1077, 12'd2072, 12'd2073, 4'h0, 8'h40});
    send_poll('{12'hAAA,  12'h555,  12'h800,  12'h7FF,  4'h0, 8'h80});
    send_poll('{12'h555,  12'hAAA,  12'h7FF,  12'h800,  4'h0, 8'h1F});
    send_poll('{12'd1,    12'd3000, 12'd1500, 12'd4094, 4'h0, 8'h60});
    drain_reports();
  endtask

  // Lock, hold past release of the opposite key, unlock, fresh pairs, held pairs
  task automatic test_socd_sequences();
    logic [DIR_W-1:0] seq[16] = '{4'h1, 4'h3, 4'h1, 4'h0, 4'h1, 4'h3, 4'h2, 4'h3,
                                  4'h0, 4'h3, 4'h3, 4'h4, 4'hC, 4'hF, 4'h8, 4'h0};
    foreach (seq[i])
      send_poll('{SB'(2000 + 40 * i), SB'(1200), SB'(2500), SB'(900), seq[i], BTN_W'(i)});
    drain_reports();
  endtask

  // Random polls; keys mostly evolve one press or release at a time
  task automatic test_random_polls(input int unsigned n);
    poll_t p;
    logic [DIR_W-1:0] keys;
    int unsigned r;
    keys = '0;
    for (int unsigned i = 0; i < n; i++) begin
      // long opening stretch with no idling on either side
      in_idle_pct  = (i < 300) ? 0 : 32;
      out_idle_pct = (i < 300) ? 0 : 32;
      r = $urandom_range(0, 99);
      if (r < 55)      keys[$urandom_range(0, DIR_W - 1)] ^= 1'b1;
      else if (r < 75) keys = keys;
      else if (r < 90) keys = DIR_W'($urandom);
      else             keys ^= (2'b11 << (2 * $urandom_range(0, 1)));
      p.ch0 = pick_sample();
      p.ch1 = pick_sample();
      p.ch2 = pick_sample();
      p.ch3 = pick_sample();
      p.dir = keys;
      p.btn = BTN_W'($urandom);
      send_poll(p);
    end
    drain_reports();
  endtask

  // Receiver holds off while the sender keeps offering words, filling the block
  task automatic test_receiver_hold_off(input int unsigned n);
    poll_t p;
    in_idle_pct  = 0;
    out_idle_pct = 32;
    hold_len     = HOLD_OFF_LEN;
    hold_id++;
    for (int unsigned i = 0; i < n; i++) begin
      p.ch0 = pick_sample();
      p.ch1 = pick_sample();
      p.ch2 = pick_sample();
      p.ch3 = pick_sample();
      p.dir = DIR_W'($urandom);
      p.btn = BTN_W'($urandom);
      send_poll(p);
    end
    drain_reports();
  endtask

  // Receiver stall: random idling plus hold-off stretches requested by the tests
  always @(negedge clk) begin
    if (hold_id != hold_taken) begin
      hold_taken = hold_id;
      hold_left  = hold_len;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  // Compare each report word taken with the oldest queued expectation
  always @(posedge clk) begin
    report_t want;
    if (!rst && out_valid && !out_stall) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $error("report word taken with no poll pending");
        err_cnt++;
      end else begin
        want = pending_reports.pop_front();
        check_field("main_x_report", want.main_x, main_x_report);
        check_field("main_y_report", want.main_y, main_y_report);
        check_field("cstick_x_report", want.cs_x, cstick_x_report);
        check_field("cstick_y_report", want.cs_y, cstick_y_report);
        check_field("pad_left", want.pad[DIR_LEFT], pad_left);
        check_field("pad_right", want.pad[DIR_RIGHT], pad_right);
        check_field("pad_up", want.pad[DIR_UP], pad_up);
        check_field("pad_down", want.pad[DIR_DOWN], pad_down);
        check_field("trigger_left_level", want.trig_l, trigger_left_level);
        check_field("trigger_right_level", want.trig_r, trigger_right_level);
        check_field("button_report", want.btn, button_report);
      end
    end
  end

  // End the run when no word moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    out_stall      = 1'b0;
    adc_sample_ch0 = '0;
    adc_sample_ch1 = '0;
    adc_sample_ch2 = '0;
    adc_sample_ch3 = '0;
    direction_keys = '0;
    button_keys    = '0;
    key_history    = '0;
    dir_lock       = '0;
    err_cnt        = 0;
    polls_sent     = 0;
    reports_seen   = 0;
    locks_set      = 0;
    in_idle_pct    = 32;
    out_idle_pct   = 32;
    hold_len       = 0;
    hold_id        = 0;
    hold_taken     = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_sample_extremes();
    test_socd_sequences();
    test_random_polls(1600);
    test_receiver_hold_off(60);

    if (pending_reports.size() != 0) begin
      $error("%0d expected reports never arrived", pending_reports.size());
      err_cnt++;
    end
    $display("Run covered %0d polls and %0d reports, %0d direction locks set;",
             polls_sent, reports_seen, locks_set);
    $display("clamp edges, SOCD lock sequences, random polls, idling and a long hold-off.");
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
